### rtl/tcw_pkg.sv
// Shared definitions for the text console writer: screen geometry, codes,
// and the command and status bundles between controller and datapath.
// No dependencies.
package tcw_pkg;

   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = ROWS * COLUMNS;

   localparam int ROW_W   = 5;
   localparam int COL_W   = 7;
   localparam int ADDR_W  = 11;
   localparam int CELL_W  = 16;
   localparam int BYTE_W  = 8;
   localparam int FUNC_W  = 2;

   localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

   localparam logic [BYTE_W-1:0] NEWLINE_CODE      = 8'd10;
   localparam logic [BYTE_W-1:0] SPACE_CODE        = 8'd32;
   localparam logic [BYTE_W-1:0] CLEAR_COLOR_RESET = 8'd7;

   typedef struct packed {
      logic latch;
      logic sweep_start;
      logic sweep_item;
      logic sweep_write;
      logic put;
      logic put_live;
      logic read;
      logic load_rsp;
   } tcw_cmd_type;

   typedef struct packed {
      logic row_full;
      logic sweep_last;
      logic addr_ok;
   } tcw_status_type;

endpackage

### rtl/tcw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/tcw_ctrl.sv
// Controller state machine of the text console writer.
// Depends on tcw_pkg; drives the commands of tcw_datapath.
module tcw_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic [tcw_pkg::FUNC_W-1:0]    req_func,
   input  logic                          rsp_tready,
   input  tcw_pkg::tcw_status_type       status,
   output tcw_pkg::tcw_cmd_type          cmd,
   output logic                          req_tready,
   output logic                          rsp_tvalid
);

   localparam logic [2:0] S_INIT   = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_SWEEP  = 3'd2;
   localparam logic [2:0] S_PUT    = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       sweep_put_ff, sweep_put_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      sweep_put_in = sweep_put_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      unique case (state_ff)
         S_INIT: begin
            cmd.sweep_write = 1'b1;
            if (status.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               state_in  = S_FINISH;
               unique case (req_func)
                  tcw_pkg::FUNC_PUT: begin
                     if (status.row_full) begin
                        cmd.sweep_start = 1'b1;
                        sweep_put_in    = 1'b1;
                        state_in        = S_SWEEP;
                     end else begin
                        cmd.put      = 1'b1;
                        cmd.put_live = 1'b1;
                     end
                  end
                  tcw_pkg::FUNC_CLEAR: begin
                     cmd.sweep_start = 1'b1;
                     cmd.sweep_item  = 1'b1;
                     sweep_put_in    = 1'b0;
                     state_in        = S_SWEEP;
                  end
                  tcw_pkg::FUNC_READ: begin
                     cmd.read = status.addr_ok;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SWEEP: begin
            cmd.sweep_write = 1'b1;
            if (status.sweep_last) begin
               state_in = sweep_put_ff ? S_PUT : S_FINISH;
            end
         end
         S_PUT: begin
            cmd.put  = 1'b1;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         sweep_put_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_put_ff <= sweep_put_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SWEEP || state_ff == S_INIT) |-> !req_tready)
      else $error("Transaction accepted during a clearing pass.");

   a_put_follows_sweep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PUT) |-> $past(state_ff) == S_SWEEP && sweep_put_ff)
      else $error("Deferred put without a preceding overflow clear.");

   a_rsp_loaded_only_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_tready))
      else $error("Result register overwritten before it was taken.");

endmodule

### rtl/tcw_datapath.sv
// Datapath of the text console writer: cursor, sweep counter, cell RAM,
// and the result register. Depends on tcw_pkg and tcw_ram.
module tcw_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  tcw_pkg::tcw_cmd_type          cmd,
   output tcw_pkg::tcw_status_type       status,
   input  logic [tcw_pkg::BYTE_W-1:0]    req_char_code,
   input  logic [tcw_pkg::BYTE_W-1:0]    req_cell_color,
   input  logic [tcw_pkg::ADDR_W-1:0]    req_cell_address,
   input  logic                          csr_wr_en,
   input  logic [tcw_pkg::BYTE_W-1:0]    csr_wr_data,
   output logic [tcw_pkg::ROW_W-1:0]     rsp_cursor_row,
   output logic [tcw_pkg::COL_W-1:0]     rsp_cursor_column,
   output logic [tcw_pkg::ADDR_W-1:0]    rsp_cursor_position,
   output logic [tcw_pkg::CELL_W-1:0]    rsp_read_cell
);

   localparam int ADDR_W = tcw_pkg::ADDR_W;

   logic [tcw_pkg::ROW_W-1:0]  row_ff, row_in;
   logic [tcw_pkg::COL_W-1:0]  col_ff, col_in;
   logic [ADDR_W-1:0]          sweep_ff, sweep_in;
   logic [tcw_pkg::BYTE_W-1:0] sweep_color_ff, sweep_color_in;
   logic [tcw_pkg::BYTE_W-1:0] clear_color_ff;
   logic [tcw_pkg::BYTE_W-1:0] code_ff, color_ff;
   logic                       rd_hit_ff, rd_hit_in;

   logic [tcw_pkg::ROW_W-1:0]  out_row_ff;
   logic [tcw_pkg::COL_W-1:0]  out_col_ff;
   logic [ADDR_W-1:0]          out_pos_ff;
   logic [tcw_pkg::CELL_W-1:0] out_cell_ff;

   logic [tcw_pkg::BYTE_W-1:0] put_code, put_color;
   logic                       put_newline;
   logic [ADDR_W-1:0]          cursor_idx;
   logic                       ram_wr_en;
   logic [ADDR_W-1:0]          ram_wr_addr;
   logic [tcw_pkg::CELL_W-1:0] ram_wr_data;
   logic [tcw_pkg::CELL_W-1:0] ram_rd_data;

   assign put_code    = cmd.put_live ? req_char_code : code_ff;
   assign put_color   = cmd.put_live ? req_cell_color : color_ff;
   assign put_newline = (put_code == tcw_pkg::NEWLINE_CODE);
   assign cursor_idx  = ADDR_W'(row_ff) * ADDR_W'(tcw_pkg::COLUMNS) + ADDR_W'(col_ff);

   assign status.row_full   = (row_ff == tcw_pkg::ROW_W'(tcw_pkg::ROWS));
   assign status.sweep_last = (sweep_ff == ADDR_W'(tcw_pkg::CELL_COUNT - 1));
   assign status.addr_ok    = (req_cell_address < ADDR_W'(tcw_pkg::CELL_COUNT));

   always_comb begin
      row_in         = row_ff;
      col_in         = col_ff;
      sweep_in       = sweep_ff;
      sweep_color_in = sweep_color_ff;
      rd_hit_in      = rd_hit_ff;
      if (cmd.latch) begin
         rd_hit_in = 1'b0;
      end
      if (cmd.read) begin
         rd_hit_in = 1'b1;
      end
      if (cmd.sweep_start) begin
         sweep_in       = '0;
         sweep_color_in = cmd.sweep_item ? req_cell_color : clear_color_ff;
         row_in         = '0;
         col_in         = '0;
      end
      if (cmd.sweep_write) begin
         sweep_in = status.sweep_last ? '0 : sweep_ff + ADDR_W'(1);
      end
      if (cmd.put) begin
         if (put_newline) begin
            row_in = row_ff + tcw_pkg::ROW_W'(1);
            col_in = '0;
         end else if (col_ff == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1)) begin
            col_in = '0;
            row_in = (row_ff == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)) ? '0
                     : row_ff + tcw_pkg::ROW_W'(1);
         end else begin
            col_in = col_ff + tcw_pkg::COL_W'(1);
         end
      end
   end

   always_comb begin
      ram_wr_en   = cmd.sweep_write | (cmd.put & ~put_newline);
      ram_wr_addr = cmd.sweep_write ? sweep_ff : cursor_idx;
      ram_wr_data = cmd.sweep_write ? {sweep_color_ff, tcw_pkg::SPACE_CODE}
                                    : {put_color, put_code};
   end

   tcw_ram #(
      .WIDTH(tcw_pkg::CELL_W),
      .DEPTH(tcw_pkg::CELL_COUNT)
   ) u_cells (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (cmd.read),
      .rd_addr(req_cell_address),
      .rd_data(ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff         <= '0;
         col_ff         <= '0;
         sweep_ff       <= '0;
         sweep_color_ff <= tcw_pkg::CLEAR_COLOR_RESET;
         clear_color_ff <= tcw_pkg::CLEAR_COLOR_RESET;
         rd_hit_ff      <= 1'b0;
      end else begin
         row_ff         <= row_in;
         col_ff         <= col_in;
         sweep_ff       <= sweep_in;
         sweep_color_ff <= sweep_color_in;
         rd_hit_ff      <= rd_hit_in;
         if (csr_wr_en) begin
            clear_color_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         code_ff  <= req_char_code;
         color_ff <= req_cell_color;
      end
      if (cmd.load_rsp) begin
         out_row_ff  <= row_ff;
         out_col_ff  <= col_ff;
         out_pos_ff  <= cursor_idx;
         out_cell_ff <= rd_hit_ff ? ram_rd_data : '0;
      end
   end

   assign rsp_cursor_row      = out_row_ff;
   assign rsp_cursor_column   = out_col_ff;
   assign rsp_cursor_position = out_pos_ff;
   assign rsp_read_cell       = out_cell_ff;

   a_column_in_range: assert property (@(posedge clock) disable iff (reset)
      col_ff < tcw_pkg::COL_W'(tcw_pkg::COLUMNS))
      else $error("Cursor column beyond the row end.");

   a_full_row_at_column_zero: assert property (@(posedge clock) disable iff (reset)
      status.row_full |-> col_ff == '0)
      else $error("Cursor past the last row with a nonzero column.");

   a_put_never_when_full: assert property (@(posedge clock) disable iff (reset)
      cmd.put |-> !status.row_full)
      else $error("Character stored while the cursor is past the last row.");

endmodule

### rtl/text_console_writer.sv
// Top level of the text console writer: streaming ports, configuration register.
// Depends on tcw_pkg, tcw_ctrl, tcw_datapath and tcw_ram.
//
// After reset the block runs a clearing pass over all 2000 cells, one cell a cycle, and
// takes no transaction until it ends; clear_color writes are taken meanwhile. In a put
// or a read the accept cycle writes or reads the cell RAM, and the FINISH state then
// loads the result register once it is free. A clear, and a put that finds the cursor
// past the last row, first rewrite every cell through the one RAM write port; such a
// put then stores its character in the PUT state. The next transaction is accepted while
// the previous result still waits in the result register.
module text_console_writer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // char_code[7:0], cell_color[15:8], cell_address[26:16], zero fill
   input  logic [31:0] req_tdata,
   // func[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // cursor_row[4:0], cursor_column[11:5], cursor_position[22:12],
   // read_cell[38:23], zero fill
   output logic [39:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   tcw_pkg::tcw_cmd_type    cmd;
   tcw_pkg::tcw_status_type status;

   logic [tcw_pkg::ROW_W-1:0]  cursor_row;
   logic [tcw_pkg::COL_W-1:0]  cursor_column;
   logic [tcw_pkg::ADDR_W-1:0] cursor_position;
   logic [tcw_pkg::CELL_W-1:0] read_cell;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_func  (req_tuser),
      .rsp_tready(rsp_tready),
      .status    (status),
      .cmd       (cmd),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid)
   );

   tcw_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_char_code      (req_tdata[7:0]),
      .req_cell_color     (req_tdata[15:8]),
      .req_cell_address   (req_tdata[26:16]),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .rsp_cursor_row     (cursor_row),
      .rsp_cursor_column  (cursor_column),
      .rsp_cursor_position(cursor_position),
      .rsp_read_cell      (read_cell)
   );

   assign rsp_tdata = {1'b0, read_cell, cursor_position, cursor_column, cursor_row};

endmodule

### tb/text_console_writer_tb.sv
// Self-checking testbench for text_console_writer: directed and random console traffic,
// with every result checked against a cycle-free model of the cell memory and cursor.
// Depends on tcw_pkg and the text_console_writer RTL.
`timescale 1ns / 100ps

module text_console_writer_tb;

   localparam int FUNC_W     = tcw_pkg::FUNC_W;
   localparam int ROW_W      = tcw_pkg::ROW_W;
   localparam int COL_W      = tcw_pkg::COL_W;
   localparam int ADDR_W     = tcw_pkg::ADDR_W;
   localparam int CELL_W     = tcw_pkg::CELL_W;
   localparam int BYTE_W     = tcw_pkg::BYTE_W;
   localparam int CELL_COUNT = tcw_pkg::CELL_COUNT;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int MAX_ADDR = (1 << ADDR_W) - 1;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [ADDR_W-1:0] pos;
      logic [CELL_W-1:0] contents;
   } cursor_report_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        csr_wr_en;
   logic [7:0]  csr_wr_data;

   logic [CELL_W-1:0] shadow_cells [CELL_COUNT];
   int                shadow_row;
   int                shadow_col;
   logic [BYTE_W-1:0] clear_color_q;
   cursor_report_type pending_reports [$];

   int error_count;
   int burst_left;
   int stall_mode;
   int stall_mode_left;
   int stall_hold;
   int idle_cycles;

   text_console_writer dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void wipe_shadow(logic [BYTE_W-1:0] color);
      for (int i = 0; i < CELL_COUNT; i++) shadow_cells[i] = {color, tcw_pkg::SPACE_CODE};
      shadow_row = 0;
      shadow_col = 0;
   endfunction

   function automatic cursor_report_type apply_command(logic [FUNC_W-1:0] func,
                                                       logic [BYTE_W-1:0] code,
                                                       logic [BYTE_W-1:0] color,
                                                       logic [ADDR_W-1:0] addr);
      cursor_report_type report;
      int index;
      int linear;
      report = '0;
      case (func)
         tcw_pkg::FUNC_PUT: begin
            if (shadow_row >= tcw_pkg::ROWS) wipe_shadow(clear_color_q);
            if (code == tcw_pkg::NEWLINE_CODE) begin
               shadow_row++;
               shadow_col = 0;
            end else begin
               index = shadow_row * tcw_pkg::COLUMNS + shadow_col;
               if (index < CELL_COUNT) shadow_cells[index] = {color, code};
               shadow_col++;
               if (shadow_col >= tcw_pkg::COLUMNS) begin
                  shadow_col = 0;
                  shadow_row++;
                  if (shadow_row >= tcw_pkg::ROWS) shadow_row = 0;
               end
            end
         end
         tcw_pkg::FUNC_CLEAR: wipe_shadow(color);
         tcw_pkg::FUNC_READ: begin
            if (addr < CELL_COUNT) report.contents = shadow_cells[addr];
         end
         default: ;
      endcase
      linear = shadow_row * tcw_pkg::COLUMNS + shadow_col;
      report.row = ROW_W'(shadow_row);
      report.col = COL_W'(shadow_col);
      report.pos = ADDR_W'(linear);
      return report;
   endfunction

   task automatic send_item(input logic [FUNC_W-1:0] func, input logic [BYTE_W-1:0] code,
                            input logic [BYTE_W-1:0] color, input logic [ADDR_W-1:0] addr);
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {5'd0, addr, color, code};
      do @(posedge clock); while (!req_tready);
      pending_reports.push_back(apply_command(func, code, color, addr));
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90)
                                                  : $urandom_range(0, 10);
      end else begin
         burst_left--;
      end
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   task automatic set_clear_color(input logic [BYTE_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      clear_color_q = value;
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [ADDR_W-1:0] pick_address();
      if ($urandom_range(0, 9) == 0) return ADDR_W'($urandom_range(CELL_COUNT, MAX_ADDR));
      return ADDR_W'($urandom_range(0, CELL_COUNT - 1));
   endfunction

   task automatic test_power_on_contents;
      send_item(tcw_pkg::FUNC_READ, 8'h00, 8'h00, 11'd0);
      send_item(tcw_pkg::FUNC_READ, 8'hFF, 8'hFF, ADDR_W'(CELL_COUNT - 1));
      send_item(tcw_pkg::FUNC_READ, 8'h00, 8'h00, ADDR_W'(CELL_COUNT));
      send_item(tcw_pkg::FUNC_READ, 8'h00, 8'h00, ADDR_W'(MAX_ADDR));
      send_item(FUNC_UNUSED, 8'hFF, 8'hFF, ADDR_W'(MAX_ADDR));
   endtask

   task automatic test_put_and_read;
      send_item(tcw_pkg::FUNC_PUT, 8'h00, 8'h00, 11'd0);
      send_item(tcw_pkg::FUNC_PUT, 8'hFF, 8'hFF, ADDR_W'(MAX_ADDR));
      send_item(tcw_pkg::FUNC_PUT, 8'h41, 8'h1E, 11'h2AA);
      send_item(tcw_pkg::FUNC_PUT, tcw_pkg::NEWLINE_CODE, 8'h55, 11'h555);
      send_item(tcw_pkg::FUNC_PUT, 8'h5A, 8'hA5, 11'd0);
      send_item(tcw_pkg::FUNC_READ, 8'h00, 8'h00, 11'd0);
      send_item(tcw_pkg::FUNC_READ, 8'h00, 8'h00, 11'd1);
      send_item(tcw_pkg::FUNC_READ, 8'h00, 8'h00, 11'd2);
      send_item(tcw_pkg::FUNC_READ, 8'h00, 8'h00, ADDR_W'(tcw_pkg::COLUMNS));
   endtask

   task automatic test_clear_screen;
      send_item(tcw_pkg::FUNC_CLEAR, 8'h55, 8'hFF, 11'h555);
      send_item(tcw_pkg::FUNC_READ, 8'h00, 8'h00, 11'd0);
      send_item(tcw_pkg::FUNC_PUT, 8'h7E, 8'h3C, 11'd0);
      send_item(tcw_pkg::FUNC_CLEAR, 8'hAA, 8'h00, 11'h2AA);
      send_item(tcw_pkg::FUNC_READ, 8'h00, 8'h00, ADDR_W'(CELL_COUNT - 1));
      send_item(tcw_pkg::FUNC_READ, 8'h00, 8'h00, 11'd0);
   endtask

   // Mostly text lines, long runs and blank lines, so the cursor keeps
   // reaching the bottom row, wrapping and forcing clears.
   task automatic test_random_traffic(input int item_target);
      int sent;
      int kind;
      int count;
      sent = 0;
      while (sent < item_target) begin
         kind = $urandom_range(0, 99);
         if (kind < 50) begin
            count = $urandom_range(0, 12);
            repeat (count) send_item(tcw_pkg::FUNC_PUT, 8'($urandom_range(0, 255)),
                                     8'($urandom_range(0, 255)), pick_address());
            send_item(tcw_pkg::FUNC_PUT, tcw_pkg::NEWLINE_CODE, 8'($urandom_range(0, 255)),
                      pick_address());
            sent += count + 1;
         end else if (kind < 58) begin
            count = $urandom_range(70, 170);
            repeat (count) send_item(tcw_pkg::FUNC_PUT, 8'($urandom_range(0, 255)),
                                     8'($urandom_range(0, 255)), pick_address());
            sent += count;
         end else if (kind < 68) begin
            count = $urandom_range(1, 8);
            repeat (count) send_item(tcw_pkg::FUNC_PUT, tcw_pkg::NEWLINE_CODE,
                                     8'($urandom_range(0, 255)), pick_address());
            sent += count;
         end else if (kind < 83) begin
            count = $urandom_range(1, 4);
            repeat (count) send_item(tcw_pkg::FUNC_READ, 8'($urandom_range(0, 255)),
                                     8'($urandom_range(0, 255)), pick_address());
            sent += count;
         end else if (kind < 86) begin
            send_item(tcw_pkg::FUNC_CLEAR, 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), pick_address());
            sent++;
         end else if (kind < 90) begin
            send_item(FUNC_UNUSED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      pick_address());
            sent++;
         end else begin
            send_item(FUNC_W'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), ADDR_W'($urandom_range(0, MAX_ADDR)));
            sent++;
         end
      end
   endtask

   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      error_count = 0;
      burst_left = $urandom_range(0, 10);
      clear_color_q = tcw_pkg::CLEAR_COLOR_RESET;
      wipe_shadow(tcw_pkg::CLEAR_COLOR_RESET);
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_power_on_contents();
      test_put_and_read();
      test_clear_screen();
      drain();
      set_clear_color(8'h00);
      test_random_traffic(250);
      drain();
      set_clear_color(8'hFF);
      test_random_traffic(250);
      drain();
      set_clear_color(8'($urandom_range(0, 255)));
      test_random_traffic(250);
      drain();
      set_clear_color(8'($urandom_range(0, 255)));
      test_random_traffic(250);
      drain();
      repeat (20) @(posedge clock);

      if (error_count == 0) begin
         $display("text_console_writer: match");
      end else begin
         $display("text_console_writer: mismatch");
      end
      $finish;
   end

   always @(posedge clock) begin
      if (stall_mode_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_mode_left = $urandom_range(50, 300);
      end else begin
         stall_mode_left--;
      end
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         default: begin
            if (stall_hold != 0) begin
               stall_hold--;
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
               stall_hold = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
            end
         end
      endcase
   end

   initial begin
      stall_mode = 0;
      stall_mode_left = 0;
      stall_hold = 0;
   end

   always @(posedge clock) begin
      cursor_report_type expected;
      cursor_report_type actual;
      if (!reset && rsp_tvalid && rsp_tready) begin
         actual.row      = rsp_tdata[4:0];
         actual.col      = rsp_tdata[11:5];
         actual.pos      = rsp_tdata[22:12];
         actual.contents = rsp_tdata[38:23];
         if (pending_reports.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("Unexpected transaction: row %0d col %0d pos %0d cell %h",
                        actual.row, actual.col, actual.pos, actual.contents);
         end else begin
            expected = pending_reports.pop_front();
            if (actual.row != expected.row || actual.col != expected.col ||
                actual.pos != expected.pos || actual.contents != expected.contents) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("Bad result: expected row %0d col %0d pos %0d cell %h, %s %0d %0d %0d %h",
                           expected.row, expected.col, expected.pos, expected.contents,
                           "got", actual.row, actual.col, actual.pos, actual.contents);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout after %0d cycles without a transaction.", idle_cycles);
            $display("text_console_writer: mismatch");
            $finish;
         end
      end
   end

endmodule
